// ===== hdl/mht_pkg.sv =====
// ----------------------------------------------------------------------------
// mht_pkg
// Shared sizes, codes and entry layout for the mnemonic hash table.
// ----------------------------------------------------------------------------
package mht_pkg;

    localparam int NUM_BUCKETS = 20;
    localparam int CAPACITY    = 64;
    localparam int KEY_CHARS   = 8;

    localparam int KEY_W  = 64;
    localparam int OPC_W  = 8;
    localparam int CLS_W  = 2;
    localparam int STAT_W = 2;
    localparam int FMT_W  = 3;

    // link values run 0..CAPACITY, CAPACITY being the null link
    localparam int LINK_W = $clog2(CAPACITY + 1);
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int BKT_W  = $clog2(NUM_BUCKETS);

    // bucket = (c0 + c1) mod NUM_BUCKETS via reciprocal multiply
    localparam int SUM_W   = 9;
    localparam int RECIP_S = 16;
    localparam int RECIP   = (1 << RECIP_S) / NUM_BUCKETS;
    localparam int PROD_W  = SUM_W + RECIP_S;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    localparam logic [CLS_W-1:0] CLS_FMT1 = 2'd0;
    localparam logic [CLS_W-1:0] CLS_FMT2 = 2'd1;

    localparam logic [FMT_W-1:0] FMT_NONE = 3'd0;
    localparam logic [FMT_W-1:0] FMT_1    = 3'd1;
    localparam logic [FMT_W-1:0] FMT_2    = 3'd2;
    localparam logic [FMT_W-1:0] FMT_3    = 3'd3;
    localparam logic [FMT_W-1:0] FMT_4    = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [OPC_W-1:0]  opcode;
        logic [CLS_W-1:0]  cls;
        logic [LINK_W-1:0] link;
    } t_entry;

endpackage

// ===== hdl/mht_key_hash.sv =====
// ----------------------------------------------------------------------------
// mht_key_hash
// Trims a raw mnemonic to its key and computes the bucket index.
// ----------------------------------------------------------------------------
module mht_key_hash (
    input  logic [mht_pkg::KEY_W-1:0] i_mnemonic,
    output logic [mht_pkg::KEY_W-1:0] o_key,
    output logic [mht_pkg::BKT_W-1:0] o_bucket
);
    import mht_pkg::*;

    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  quot;
    logic [SUM_W:0]    rem;

    // key ends at the first zero byte or after KEY_CHARS characters
    always_comb begin
        logic       run;
        logic [7:0] ch;
        run   = 1'b1;
        o_key = '0;
        for (int i = 0; i < 8; i++) begin
            ch = i_mnemonic[KEY_W-1-8*i -: 8];
            if (i >= KEY_CHARS || ch == 8'd0) begin
                run = 1'b0;
            end
            if (run) begin
                o_key[KEY_W-1-8*i -: 8] = ch;
            end
        end
    end

    always_comb begin
        sum  = SUM_W'(o_key[KEY_W-1 -: 8]) + SUM_W'(o_key[KEY_W-9 -: 8]);
        prod = PROD_W'(sum) * PROD_W'(RECIP);
        quot = prod[PROD_W-1 -: SUM_W];
        // quotient is exact or one low
        rem  = (SUM_W+1)'(sum) - (SUM_W+1)'((SUM_W+1)'(quot) * (SUM_W+1)'(NUM_BUCKETS));
        if (rem >= (SUM_W+1)'(NUM_BUCKETS)) begin
            rem = rem - (SUM_W+1)'(NUM_BUCKETS);
        end
        o_bucket = rem[BKT_W-1:0];
    end

endmodule

// ===== hdl/mnemonic_hash_table.sv =====
// Sequence: an insert passes S_HEAD then S_RES; a lookup passes S_HEAD, then S_WALK
//   if its bucket holds a chain, reading entries until a match or the end, then S_RES.
// One item at a time: a new request is taken only in S_IDLE; a lookup walks the
//   chain through the single read port of the entry memory.
// Reset (synchronous, active low) clears state, bucket valid bits, entry count
//   and the output valid bit; entry memory contents are not cleared.
// ----------------------------------------------------------------------------
// mnemonic_hash_table
// Opcode table as a chained hash table: insert at chain head, lookup newest.
// ----------------------------------------------------------------------------
module mnemonic_hash_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_req_type,
    input  logic [mht_pkg::KEY_W-1:0]   i_mnemonic,
    input  logic                        i_extended,
    input  logic [mht_pkg::OPC_W-1:0]   i_opcode_in,
    input  logic [mht_pkg::CLS_W-1:0]   i_format_class,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [mht_pkg::STAT_W-1:0]  o_status,
    output logic [mht_pkg::OPC_W-1:0]   o_opcode_value,
    output logic [mht_pkg::FMT_W-1:0]   o_format
);
    import mht_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_HEAD = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_RES  = 2'd3;

    logic [1:0] r_state, n_state;

    logic [KEY_W-1:0] hk_key;
    logic [BKT_W-1:0] hk_bucket;

    logic             r_req;
    logic [KEY_W-1:0] r_key;
    logic             r_ext;
    logic [OPC_W-1:0] r_opc;
    logic [CLS_W-1:0] r_cls;
    logic [BKT_W-1:0] r_bkt;

    logic [LINK_W-1:0] r_count;
    logic [NUM_BUCKETS-1:0] r_hvalid;

    logic [IDX_W-1:0] head_mem [NUM_BUCKETS];
    logic [IDX_W-1:0] r_head_q;
    t_entry           ent_mem [CAPACITY];
    t_entry           r_ent_q;

    logic [LINK_W-1:0] head_link;
    logic [IDX_W-1:0]  ent_raddr;
    logic              ent_we;
    logic              in_xfer;
    logic              out_free;
    logic              full;
    logic              key_hit;
    logic [FMT_W-1:0]  hit_fmt;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_res_stat, r_status;
    logic [OPC_W-1:0]  r_res_opc, r_opcode_value;
    logic [FMT_W-1:0]  r_res_fmt, r_format;

    mht_key_hash u_key_hash (
        .i_mnemonic (i_mnemonic),
        .o_key      (hk_key),
        .o_bucket   (hk_bucket)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign full       = (r_count == NULL_LINK);
    assign head_link  = r_hvalid[r_bkt] ? LINK_W'(r_head_q) : NULL_LINK;
    assign ent_we     = (r_state == S_HEAD) && (r_req == REQ_INSERT) && !full;
    assign ent_raddr  = (r_state == S_HEAD) ? head_link[IDX_W-1:0]
                                            : r_ent_q.link[IDX_W-1:0];
    assign key_hit    = (r_ent_q.key == r_key);

    always_comb begin
        case (r_ent_q.cls)
            CLS_FMT1: hit_fmt = FMT_1;
            CLS_FMT2: hit_fmt = FMT_2;
            default:  hit_fmt = r_ext ? FMT_4 : FMT_3;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) n_state = S_HEAD;
            end
            S_HEAD: begin
                if (r_req == REQ_LOOKUP && head_link != NULL_LINK) n_state = S_WALK;
                else n_state = S_RES;
            end
            S_WALK: begin
                if (key_hit || r_ent_q.link == NULL_LINK) n_state = S_RES;
            end
            S_RES: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memories: synchronous read, one write port each
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            ent_mem[r_count[IDX_W-1:0]] <= '{key: r_key, opcode: r_opc, cls: r_cls,
                                             link: head_link};
            head_mem[r_bkt] <= r_count[IDX_W-1:0];
        end
        r_head_q <= head_mem[hk_bucket];
        r_ent_q  <= ent_mem[ent_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_hvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ent_we) begin
                r_count         <= r_count + 1'b1;
                r_hvalid[r_bkt] <= 1'b1;
            end
            if (r_state == S_RES && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_req <= i_req_type;
            r_key <= hk_key;
            r_ext <= i_extended;
            r_opc <= i_opcode_in;
            r_cls <= i_format_class;
            r_bkt <= hk_bucket;
        end
        if (r_state == S_HEAD) begin
            r_res_opc <= '0;
            r_res_fmt <= FMT_NONE;
            if (r_req == REQ_INSERT) r_res_stat <= full ? ST_FULL : ST_OK;
            else r_res_stat <= ST_NOT_FOUND;
        end else if (r_state == S_WALK && key_hit) begin
            r_res_stat <= ST_OK;
            r_res_opc  <= r_ent_q.opcode;
            r_res_fmt  <= hit_fmt;
        end
        if (r_state == S_RES && out_free) begin
            r_status       <= r_res_stat;
            r_opcode_value <= r_res_opc;
            r_format       <= r_res_fmt;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_opcode_value = r_opcode_value;
    assign o_format       = r_format;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NULL_LINK)
        else $error("entry count beyond capacity");

    a_head_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HEAD && r_req == REQ_LOOKUP && head_link != NULL_LINK)
        |-> head_link < r_count)
        else $error("chain head points at unwritten entry");

    a_link_older: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && !key_hit && r_ent_q.link != NULL_LINK)
        |-> r_ent_q.link < r_count)
        else $error("chain link points at unwritten entry");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ent_we |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not advance entry count");

    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RES && out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("result not delivered to output register");

endmodule

// ===== bench/tb_mnemonic_hash_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mnemonic_hash_table
// Self-checking bench for the mnemonic hash table. A short directed sequence
// covers empty-table lookups, every format class, the extended flag, key
// normalization, short keys, bucket collisions and duplicates. A long random
// sequence of inserts and lookups then fills the store and runs into
// table-full. Replies are predicted by a local table model and compared per
// field. Both sides idle randomly, and the receiver holds off twice for a long
// stretch so the block backs up.
// ----------------------------------------------------------------------------
module tb_mnemonic_hash_table;

    import mht_pkg::*;

    localparam int N_RANDOM    = 1780;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic              req;
        logic [KEY_W-1:0]  mnem;
        logic              ext;
        logic [OPC_W-1:0]  opc;
        logic [CLS_W-1:0]  cls;
    } t_request;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OPC_W-1:0]  opcode;
        logic [FMT_W-1:0]  fmt;
    } t_reply;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_stall;
    logic               i_req_type     = REQ_INSERT;
    logic [KEY_W-1:0]   i_mnemonic     = '0;
    logic               i_extended     = 1'b0;
    logic [OPC_W-1:0]   i_opcode_in    = '0;
    logic [CLS_W-1:0]   i_format_class = '0;
    logic               o_out_valid;
    logic               i_out_stall    = 1'b1;
    logic [STAT_W-1:0]  o_status;
    logic [OPC_W-1:0]   o_opcode_value;
    logic [FMT_W-1:0]   o_format;

    mnemonic_hash_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_mnemonic     (i_mnemonic),
        .i_extended     (i_extended),
        .i_opcode_in    (i_opcode_in),
        .i_format_class (i_format_class),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_opcode_value (o_opcode_value),
        .o_format       (o_format)
    );

    always #1 i_clk = ~i_clk;

    // local copy of the table
    logic [LINK_W-1:0] tbl_head [NUM_BUCKETS];
    logic [KEY_W-1:0]  tbl_key  [CAPACITY];
    logic [OPC_W-1:0]  tbl_opc  [CAPACITY];
    logic [CLS_W-1:0]  tbl_cls  [CAPACITY];
    logic [LINK_W-1:0] tbl_link [CAPACITY];
    int                tbl_count;

    t_request          request_q [$];
    t_reply            reply_q [$];
    logic [KEY_W-1:0]  name_pool [$];

    int   n_total    = 0;
    int   n_sent     = 0;
    int   n_errors   = 0;
    int   cycle_cnt  = 0;
    int   gap_left   = 0;
    int   stall_left = 0;
    int   hold_cnt   = 0;
    int   hold_round = 0;
    logic run_en     = 1'b0;
    logic in_took    = 1'b0;
    logic hold_off;

    assign hold_off = (hold_cnt > 0);

    function automatic t_reply predict_table_reply(t_request rq);
        t_reply           rp;
        logic [KEY_W-1:0] key;
        logic [LINK_W-1:0] p;
        logic             ended;
        logic             found;
        int               b;
        int               steps;
        rp = '{ST_OK, '0, FMT_NONE};
        key = '0;
        ended = 1'b0;
        // key stops at the first zero byte
        for (int i = 0; i < KEY_CHARS; i++) begin
            if (rq.mnem[KEY_W-1-8*i -: 8] == 8'h00) ended = 1'b1;
            if (!ended) key[KEY_W-1-8*i -: 8] = rq.mnem[KEY_W-1-8*i -: 8];
        end
        b = (int'(key[KEY_W-1 -: 8]) + int'(key[KEY_W-9 -: 8])) % NUM_BUCKETS;
        if (rq.req == REQ_INSERT) begin
            if (tbl_count >= CAPACITY) begin
                rp.status = ST_FULL;
            end else begin
                tbl_key[tbl_count]  = key;
                tbl_opc[tbl_count]  = rq.opc;
                tbl_cls[tbl_count]  = rq.cls;
                tbl_link[tbl_count] = tbl_head[b];
                tbl_head[b] = LINK_W'(tbl_count);
                tbl_count++;
            end
        end else begin
            p = tbl_head[b];
            found = 1'b0;
            for (steps = 0; steps < CAPACITY && p != NULL_LINK && !found; steps++) begin
                if (tbl_key[p] == key) begin
                    found = 1'b1;
                    rp.opcode = tbl_opc[p];
                    if (tbl_cls[p] == CLS_FMT1) rp.fmt = FMT_1;
                    else if (tbl_cls[p] == CLS_FMT2) rp.fmt = FMT_2;
                    else rp.fmt = rq.ext ? FMT_4 : FMT_3;
                end else begin
                    p = tbl_link[p];
                end
            end
            if (!found) rp.status = ST_NOT_FOUND;
        end
        return rp;
    endfunction

    function automatic logic [KEY_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [KEY_W-1:0] pack_name(string s);
        logic [KEY_W-1:0] k;
        k = '0;
        for (int i = 0; i < s.len() && i < 8; i++) k[KEY_W-1-8*i -: 8] = s[i];
        return k;
    endfunction

    // random bytes after the terminator; they must not affect the key
    function automatic logic [KEY_W-1:0] dirty_tail(logic [KEY_W-1:0] k);
        int len;
        len = 0;
        while (len < 8 && k[KEY_W-1-8*len -: 8] != 8'h00) len++;
        if (len >= 7) return k;
        return k | (rand64() & ({KEY_W{1'b1}} >> (8 * (len + 1))));
    endfunction

    function automatic logic [KEY_W-1:0] make_name();
        logic [KEY_W-1:0] k;
        int len;
        k = '0;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : $urandom_range(2, 6);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 4) == 0) k[KEY_W-1-8*i -: 8] = 8'($urandom_range(1, 255));
            else k[KEY_W-1-8*i -: 8] = 8'($urandom_range(65, 90));
        end
        return k;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    task automatic add_req(logic req, logic [KEY_W-1:0] mnem, logic ext,
                           logic [OPC_W-1:0] opc, logic [CLS_W-1:0] cls);
        request_q.push_back('{req, mnem, ext, opc, cls});
        if (req == REQ_INSERT) name_pool.push_back(mnem);
        n_total++;
    endtask

    task automatic check_field(string what, int exp_v, int got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
            n_errors++;
        end
    endtask

    // sender: one item at a time from the queue, random gaps between transfers
    always @(negedge i_clk) begin
        t_request nxt;
        logic     v;
        int       gap;
        if (run_en) begin
            v = i_in_valid;
            gap = gap_left;
            if (in_took) begin
                v = 1'b0;
                gap = ((n_sent % 300) < 60) ? 0 : idle_len();
            end
            if (!v) begin
                if (gap > 0) begin
                    gap--;
                end else if (request_q.size() > 0) begin
                    nxt = request_q.pop_front();
                    i_req_type     <= nxt.req;
                    i_mnemonic     <= nxt.mnem;
                    i_extended     <= nxt.ext;
                    i_opcode_in    <= nxt.opc;
                    i_format_class <= nxt.cls;
                    v = 1'b1;
                end
            end
            gap_left = gap;
            i_in_valid <= v;
        end
    end

    // receiver: random stalls plus the long hold-off
    always @(negedge i_clk) begin
        logic s;
        int   len;
        s = 1'b0;
        if (stall_left > 0) begin
            stall_left--;
            s = 1'b1;
        end else if ((cycle_cnt % 3000) >= 400 && $urandom_range(0, 3) == 0) begin
            len = idle_len();
            if (len > 0) begin
                s = 1'b1;
                stall_left = len - 1;
            end
        end
        i_out_stall <= (s || hold_off) && run_en;
    end

    always @(posedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if ((hold_round == 0 && n_sent >= 400) ||
                     (hold_round == 1 && n_sent >= 1300)) begin
            hold_cnt   <= HOLD_CYCLES;
            hold_round <= hold_round + 1;
        end
    end

    // input transfers feed the predictor, output transfers are checked
    always @(posedge i_clk) begin
        t_reply exp_r;
        in_took <= i_in_valid && !o_in_stall;
        if (i_in_valid && !o_in_stall) begin
            reply_q.push_back(predict_table_reply('{i_req_type, i_mnemonic, i_extended,
                                                    i_opcode_in, i_format_class}));
            n_sent <= n_sent + 1;
        end
        if (o_out_valid && !i_out_stall) begin
            if (reply_q.size() == 0) begin
                $display({"%0t: unexpected reply, expected none, ",
                          "got status %0d opcode %0d format %0d"},
                         $time, o_status, o_opcode_value, o_format);
                n_errors++;
            end else begin
                exp_r = reply_q.pop_front();
                check_field("status", exp_r.status, o_status);
                check_field("opcode_value", exp_r.opcode, o_opcode_value);
                check_field("format", exp_r.fmt, o_format);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_mnemonic_hash_table: done, errors");
            $finish;
        end
    end

    initial begin
        logic [KEY_W-1:0] k;
        int               r;
        for (int i = 0; i < NUM_BUCKETS; i++) tbl_head[i] = NULL_LINK;
        tbl_count = 0;

        // directed part
        add_req(REQ_LOOKUP, pack_name("LDA"), 1'b0, 8'hFF, 2'd3);        // empty table
        add_req(REQ_INSERT, pack_name("LDA"), 1'b1, 8'h00, 2'd2);        // extended ignored
        add_req(REQ_LOOKUP, pack_name("LDA"), 1'b0, 8'h00, 2'd0);
        add_req(REQ_LOOKUP, pack_name("LDA"), 1'b1, 8'hA5, 2'd1);
        add_req(REQ_INSERT, pack_name("FIX"), 1'b0, 8'hC4, CLS_FMT1);
        add_req(REQ_LOOKUP, pack_name("FIX"), 1'b1, 8'h00, 2'd0);
        add_req(REQ_INSERT, pack_name("ADDR"), 1'b0, 8'h90, CLS_FMT2);
        add_req(REQ_LOOKUP, pack_name("ADDR"), 1'b1, 8'h00, 2'd0);
        add_req(REQ_INSERT, pack_name("RSUB"), 1'b0, 8'h4C, 2'd3);       // unused class
        add_req(REQ_LOOKUP, pack_name("RSUB"), 1'b1, 8'h00, 2'd0);
        add_req(REQ_LOOKUP, pack_name("RSUB"), 1'b0, 8'h00, 2'd0);
        add_req(REQ_INSERT, pack_name("LDA"), 1'b0, 8'hFF, CLS_FMT1);    // duplicate key
        add_req(REQ_LOOKUP, pack_name("LDA"), 1'b1, 8'h00, 2'd0);
        add_req(REQ_LOOKUP, {pack_name("LDA")} | 64'h0000_0000_DEAD_BEEF, 1'b0, 8'h00, 2'd0);
        add_req(REQ_INSERT, 64'h00FF_FFFF_FFFF_FFFF, 1'b0, 8'h55, CLS_FMT2); // empty key
        add_req(REQ_LOOKUP, 64'h0, 1'b0, 8'h00, 2'd0);
        add_req(REQ_INSERT, pack_name("J"), 1'b0, 8'h3C, 2'd2);
        add_req(REQ_LOOKUP, pack_name("J") | 64'h0000_1234_5678_9ABC, 1'b1, 8'h00, 2'd0);
        add_req(REQ_INSERT, pack_name("AB"), 1'b0, 8'h11, CLS_FMT1);
        add_req(REQ_LOOKUP, pack_name("BA"), 1'b0, 8'h00, 2'd0);         // same bucket, absent
        add_req(REQ_LOOKUP, pack_name("LDX"), 1'b0, 8'h00, 2'd0);        // same bucket as LDA
        add_req(REQ_INSERT, {KEY_W{1'b1}}, 1'b0, 8'hFF, 2'd3);
        add_req(REQ_LOOKUP, {KEY_W{1'b1}}, 1'b1, 8'hFF, 2'd3);
        add_req(REQ_LOOKUP, pack_name("AB"), 1'b0, 8'hFF, 2'd3);

        // random part: sparse inserts so the store fills about midway
        for (int n = 0; n < N_RANDOM; n++) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                r = $urandom_range(0, 9);
                if (r == 0) k = rand64();
                else if (r < 3) k = name_pool[$urandom_range(0, name_pool.size() - 1)];
                else k = make_name();
                add_req(REQ_INSERT, k, 1'($urandom), 8'($urandom), 2'($urandom));
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    k = name_pool[$urandom_range(0, name_pool.size() - 1)];
                    if ($urandom_range(0, 2) == 0) k = dirty_tail(k);
                end else if (r < 85) begin
                    k = make_name();
                end else begin
                    k = rand64();
                end
                request_q.push_back('{REQ_LOOKUP, k, 1'($urandom), 8'($urandom), 2'($urandom)});
                n_total++;
            end
        end

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_en  <= 1'b1;

        while (n_sent < n_total) @(negedge i_clk);
        while (reply_q.size() > 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (n_errors == 0) begin
            $display("tb_mnemonic_hash_table: done, clean");
        end else begin
            $display("tb_mnemonic_hash_table: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/mht_pkg.sv
hdl/mht_key_hash.sv
hdl/mnemonic_hash_table.sv
bench/tb_mnemonic_hash_table.sv
